// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// Payload types of the byte and token channels, token kinds, error codes
// and the keyword spelling table.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Token kinds
  localparam logic [4:0] KIND_OP_PLUS    = 5'd0;
  localparam logic [4:0] KIND_OP_MINUS   = 5'd1;
  localparam logic [4:0] KIND_OP_STAR    = 5'd2;
  localparam logic [4:0] KIND_OP_SLASH   = 5'd3;
  localparam logic [4:0] KIND_OP_LPAREN  = 5'd4;
  localparam logic [4:0] KIND_OP_RPAREN  = 5'd5;
  localparam logic [4:0] KIND_OP_SEMI    = 5'd6;
  localparam logic [4:0] KIND_OP_LBRACE  = 5'd7;
  localparam logic [4:0] KIND_OP_RBRACE  = 5'd8;
  localparam logic [4:0] KIND_OP_GT      = 5'd9;
  localparam logic [4:0] KIND_INT        = 5'd10;
  localparam logic [4:0] KIND_ID         = 5'd11;
  localparam logic [4:0] KIND_KW_GLOBAL  = 5'd12;
  localparam logic [4:0] KIND_KW_NONE    = 5'd13;
  localparam logic [4:0] KIND_KW_ASM     = 5'd14;
  localparam logic [4:0] KIND_STR_END    = 5'd15;
  localparam logic [4:0] KIND_ID_CHAR    = 5'd16;
  localparam logic [4:0] KIND_STR_CHAR   = 5'd17;
  localparam logic [4:0] KIND_END        = 5'd18;
  localparam logic [4:0] KIND_ERROR      = 5'd19;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_DIGITS      = 3'd1;
  localparam logic [2:0] ERR_ID_LONG     = 3'd2;
  localparam logic [2:0] ERR_STR_OPEN    = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd4;

  // Saturation limits
  localparam logic [30:0] INT_MAX        = 31'h7FFF_FFFF;
  localparam logic [23:0] LINE_MAX       = 24'hFF_FFFF;

  // Letter folding bit
  localparam logic [7:0] CASE_BIT        = 8'h20;

  // Keyword lengths: global, none, __asm
  localparam int unsigned KW_COUNT = 3;
  localparam logic [5:0] KW_LEN [KW_COUNT] = '{6'd6, 6'd4, 6'd5};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } sts_byte_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [30:0] int_value;
    logic [7:0]  text_char;
    logic [23:0] line_number;
    logic [2:0]  error_code;
    logic        last;
  } sts_token_t;

  // Keyword spelling, character idx of keyword k
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0: c = "g";
          3'd1: c = "l";
          3'd2: c = "o";
          3'd3: c = "b";
          3'd4: c = "a";
          3'd5: c = "l";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0: c = "n";
          3'd1: c = "o";
          3'd2: c = "n";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: c = "_";
          3'd1: c = "_";
          3'd2: c = "a";
          3'd3: c = "s";
          3'd4: c = "m";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/sts_stream_if.sv =====
// ----------------------------------------------------------------------------
// sts_stream_if: valid/ready channel
// Carries one request per edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface sts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner: byte-serial tokenizer
// Scans source bytes into operator, integer, identifier and string tokens.
// ----------------------------------------------------------------------------
// The scanner takes one byte per cycle when the token queue has room: each
// byte is held in the input register until the queue has room, is scanned
// there and writes zero, one or two tokens into a four-entry token queue
// that drains one token per cycle while the sink is ready. A byte is taken
// every cycle while the queue holds at most two tokens, so the rate is one
// byte per cycle as long as the sink is ready and the bytes yield on average
// no more than one token each; a byte that yields two (a token ended by a
// terminator that is itself a token) adds an extra token to drain. After
// any error token the scanner drops all further bytes until reset.
module source_token_scanner #(
  parameter int unsigned MAX_ID_LEN     = 32,
  parameter int unsigned MAX_INT_DIGITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sts_stream_if.sink   in_if,
  sts_stream_if.source out_if
);

  localparam int unsigned IdW   = $clog2(MAX_ID_LEN);
  localparam int unsigned DcW   = $clog2(MAX_INT_DIGITS + 1);
  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // Scan modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_INT  = 3'd1;
  localparam logic [2:0] MODE_ID   = 3'd2;
  localparam logic [2:0] MODE_STR  = 3'd3;
  localparam logic [2:0] MODE_ESC  = 3'd4;
  localparam logic [2:0] MODE_HALT = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  function automatic sts_pkg::sts_token_t mk_tok(input logic [4:0] kind,
                                                 input logic [30:0] ival,
                                                 input logic [7:0] ch,
                                                 input logic [23:0] line,
                                                 input logic [2:0] err);
    sts_pkg::sts_token_t t;
    t.kind        = kind;
    t.int_value   = ival;
    t.text_char   = ch;
    t.line_number = line;
    t.error_code  = err;
    t.last        = 1'b0;
    return t;
  endfunction

  // Input register
  logic                  s1_valid_q;
  sts_pkg::sts_byte_t    s1_q;
  logic                  fire;

  // Scanner state
  logic [2:0]  mode_q, mode_d;
  logic [30:0] acc_q, acc_d;
  logic [DcW-1:0] dcnt_q, dcnt_d;
  logic [IdW-1:0] idlen_q, idlen_d;
  logic [2:0]  kwm_q, kwm_d;
  logic [23:0] line_q, line_d;
  logic [23:0] tline_q, tline_d;

  // Token queue
  sts_pkg::sts_token_t fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  // Scan results
  logic                pre_v, main_v;
  sts_pkg::sts_token_t pre_r, main_r;

  assign fire        = s1_valid_q && (cnt_q <= CntW'(Depth - 2));
  assign in_if.ready = !s1_valid_q || fire;

  // Hold the incoming byte in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s1_q <= in_if.data;
    end
  end

  // Operator lookup
  logic       op_hit;
  logic [4:0] op_kind;
  always_comb begin
    op_hit  = 1'b1;
    op_kind = sts_pkg::KIND_OP_PLUS;
    case (s1_q.in_byte)
      "+": op_kind = sts_pkg::KIND_OP_PLUS;
      "-": op_kind = sts_pkg::KIND_OP_MINUS;
      "*": op_kind = sts_pkg::KIND_OP_STAR;
      "/": op_kind = sts_pkg::KIND_OP_SLASH;
      "(": op_kind = sts_pkg::KIND_OP_LPAREN;
      ")": op_kind = sts_pkg::KIND_OP_RPAREN;
      ";": op_kind = sts_pkg::KIND_OP_SEMI;
      "{": op_kind = sts_pkg::KIND_OP_LBRACE;
      "}": op_kind = sts_pkg::KIND_OP_RBRACE;
      ">": op_kind = sts_pkg::KIND_OP_GT;
      default: op_hit = 1'b0;
    endcase
  end

  // Scan the held byte against the current state
  logic [7:0]     b;
  logic           eoi;
  logic           is_digit, is_id;
  logic [23:0]    lc, tl;
  logic           do_idle, do_id, do_str;
  logic [IdW-1:0] id_len_cur;
  logic [2:0]     kwm_cur;
  logic [34:0]    prod;
  logic [7:0]     folded;
  logic [4:0]     id_kind;

  always_comb begin
    b        = s1_q.in_byte;
    eoi      = s1_q.end_of_input || (b == 8'h00);
    folded   = b | sts_pkg::CASE_BIT;
    is_digit = (b >= "0") && (b <= "9");
    is_id    = ((folded >= "a") && (folded <= "z")) || (b == "_");
    prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(b - "0");

    mode_d  = mode_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    idlen_d = idlen_q;
    kwm_d   = kwm_q;
    tline_d = tline_q;

    lc = line_q;
    if (!eoi && (b == CH_LF) && (lc != sts_pkg::LINE_MAX)) begin
      lc = lc + 24'd1;
    end
    line_d = (mode_q == MODE_HALT) ? line_q : lc;

    tl         = tline_q;
    do_idle    = 1'b0;
    do_id      = 1'b0;
    do_str     = 1'b0;
    id_len_cur = idlen_q;
    kwm_cur    = kwm_q;
    pre_v      = 1'b0;
    main_v     = 1'b0;
    pre_r      = mk_tok(sts_pkg::KIND_END, '0, '0, '0, sts_pkg::ERR_NONE);
    main_r     = pre_r;

    // Closing class of the identifier held so far
    id_kind = sts_pkg::KIND_ID;
    for (int k = 0; k < sts_pkg::KW_COUNT; k++) begin
      if (kwm_q[k] && (6'(idlen_q) == sts_pkg::KW_LEN[k])) begin
        id_kind = sts_pkg::KIND_KW_GLOBAL + 5'(k);
      end
    end

    case (mode_q)
      MODE_INT: begin
        if (!eoi && is_digit) begin
          if (dcnt_q >= DcW'(MAX_INT_DIGITS)) begin
            main_v = 1'b1;
            main_r = mk_tok(sts_pkg::KIND_ERROR, '0, '0, tline_q, sts_pkg::ERR_DIGITS);
            mode_d = MODE_HALT;
          end else begin
            acc_d  = (prod > 35'(sts_pkg::INT_MAX)) ? sts_pkg::INT_MAX : prod[30:0];
            dcnt_d = dcnt_q + DcW'(1);
          end
        end else begin
          pre_v   = 1'b1;
          pre_r   = mk_tok(sts_pkg::KIND_INT, acc_q, '0, tline_q, sts_pkg::ERR_NONE);
          do_idle = 1'b1;
        end
      end
      MODE_ID: begin
        if (!eoi && is_id) begin
          do_id = 1'b1;
        end else begin
          pre_v   = 1'b1;
          pre_r   = mk_tok(id_kind, '0, '0, tline_q, sts_pkg::ERR_NONE);
          do_idle = 1'b1;
        end
      end
      MODE_STR: begin
        do_str = 1'b1;
      end
      MODE_ESC: begin
        mode_d = MODE_STR;
        if (!eoi && (b == "n")) begin
          main_v = 1'b1;
          main_r = mk_tok(sts_pkg::KIND_STR_CHAR, '0, CH_LF, tline_q, sts_pkg::ERR_NONE);
        end else if (!eoi && (b == "t")) begin
          main_v = 1'b1;
          main_r = mk_tok(sts_pkg::KIND_STR_CHAR, '0, CH_TAB, tline_q, sts_pkg::ERR_NONE);
        end else begin
          do_str = 1'b1;
        end
      end
      MODE_HALT: begin
        mode_d = MODE_HALT;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Start of a new token
    if (do_idle) begin
      tl      = lc;
      tline_d = lc;
      mode_d  = MODE_IDLE;
      if (eoi) begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_END, '0, '0, lc, sts_pkg::ERR_NONE);
      end else if ((b == CH_TAB) || (b == CH_CR) || (b == CH_LF) || (b == CH_SPACE)) begin
        main_v = 1'b0;
      end else if (op_hit) begin
        main_v = 1'b1;
        main_r = mk_tok(op_kind, '0, '0, tl, sts_pkg::ERR_NONE);
      end else if (b == CH_QUOTE) begin
        mode_d = MODE_STR;
      end else if (is_digit) begin
        mode_d = MODE_INT;
        acc_d  = 31'(b - "0");
        dcnt_d = DcW'(1);
      end else if (is_id) begin
        mode_d     = MODE_ID;
        id_len_cur = '0;
        kwm_cur    = 3'b111;
        do_id      = 1'b1;
      end else begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_ERROR, '0, b, tl, sts_pkg::ERR_BAD_CHAR);
        mode_d = MODE_HALT;
      end
    end

    // Append one identifier character
    if (do_id) begin
      if (id_len_cur >= IdW'(MAX_ID_LEN - 2)) begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_ERROR, '0, '0, tl, sts_pkg::ERR_ID_LONG);
        mode_d = MODE_HALT;
      end else begin
        for (int k = 0; k < sts_pkg::KW_COUNT; k++) begin
          if ((6'(id_len_cur) >= sts_pkg::KW_LEN[k]) ||
              (sts_pkg::kw_char(2'(k), id_len_cur[2:0]) != b)) begin
            kwm_cur[k] = 1'b0;
          end
        end
        kwm_d   = kwm_cur;
        idlen_d = id_len_cur + IdW'(1);
        main_v  = 1'b1;
        main_r  = mk_tok(sts_pkg::KIND_ID_CHAR, '0, b, tl, sts_pkg::ERR_NONE);
      end
    end

    // Ordinary string byte
    if (do_str) begin
      if (eoi) begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_ERROR, '0, '0, tline_q, sts_pkg::ERR_STR_OPEN);
        mode_d = MODE_HALT;
      end else if (b == CH_QUOTE) begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_STR_END, '0, '0, tline_q, sts_pkg::ERR_NONE);
        mode_d = MODE_IDLE;
      end else if (b == CH_BSL) begin
        mode_d = MODE_ESC;
      end else begin
        main_v = 1'b1;
        main_r = mk_tok(sts_pkg::KIND_STR_CHAR, '0, b, tline_q, sts_pkg::ERR_NONE);
      end
    end

    // Mark the final token of this byte
    if (main_v) begin
      main_r.last = 1'b1;
    end else begin
      pre_r.last = 1'b1;
    end
  end

  // Advance scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      dcnt_q  <= '0;
      idlen_q <= '0;
      kwm_q   <= 3'b111;
      line_q  <= 24'd1;
      tline_q <= 24'd1;
    end else if (fire) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      idlen_q <= idlen_d;
      kwm_q   <= kwm_d;
      line_q  <= line_d;
      tline_q <= tline_d;
    end
  end

  // Push tokens into the queue, pop one per request taken
  logic [1:0] push_n;
  assign pop    = out_if.valid && out_if.ready;
  assign push_n = fire ? ({1'b0, pre_v} + {1'b0, main_v}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (pre_v) begin
        fifo_q[wr_ptr_q] <= pre_r;
        if (main_v) begin
          fifo_q[wr_ptr_q + PtrW'(1)] <= main_r;
        end
      end else if (main_v) begin
        fifo_q[wr_ptr_q] <= main_r;
      end
    end
  end

  assign out_if.valid = (cnt_q != '0);
  assign out_if.data  = fifo_q[rd_ptr_q];

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("token queue overflow");

  // Halt holds until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (mode_q == MODE_HALT) |=> (mode_q == MODE_HALT))
    else $error("scanner left halt");

  // Line count never goes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   1'b1 |=> (line_q >= $past(line_q)))
    else $error("line count decreased");

  // Error tokens carry a code, other tokens none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_if.valid |->
                   ((out_if.data.kind == sts_pkg::KIND_ERROR) ==
                    (out_if.data.error_code != sts_pkg::ERR_NONE)))
    else $error("error code mismatch");

  // No byte is scanned once halted without holding the line count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fire && (mode_q == MODE_HALT)) |=> $stable(line_q))
    else $error("line count moved while halted");

endmodule

// ===== verif/tb_source_token_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_token_scanner: self-checking bench for the byte-serial scanner
// Feeds a short table of fixed bytes and then random, mostly well-formed
// source text, and finishes with one error sequence, since an error halts
// the block until reset. Both channels idle at random. An in-bench model
// predicts every token, and each output request is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_source_token_scanner;
  import sts_pkg::*;

  localparam int unsigned ID_LIMIT     = 32;
  localparam int unsigned DIGIT_LIMIT  = 20;
  localparam int          ITEM_TARGET  = 1530;
  localparam int          DRAIN_CYCLES = 32;
  localparam int          CYCLE_LIMIT  = 1500000;
  localparam int          DIR_ROWS     = 25;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_INT, SCAN_ID, SCAN_STR, SCAN_ESC, SCAN_HALT
  } scan_mode_e;

  // One row of the fixed byte table; typed rows carry their token kind
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        end_flag;
    logic        typed;
    logic [4:0]  kind;
    logic [23:0] line;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sts_stream_if #(.T(sts_byte_t))  byte_if ();
  sts_stream_if #(.T(sts_token_t)) token_if ();

  source_token_scanner #(
    .MAX_ID_LEN    (ID_LIMIT),
    .MAX_INT_DIGITS(DIGIT_LIMIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (byte_if),
    .out_if(token_if)
  );

  // Scanner state as predicted by the bench
  scan_mode_e  scan_mode;
  logic [30:0] int_acc;
  int unsigned digit_cnt;
  int unsigned id_len;
  logic [2:0]  kw_live;
  logic [23:0] line_cnt;
  logic [23:0] tok_line;
  string       kw_word [3] = '{"global", "none", "__asm"};
  string       op_chars = "+-*/();{}>";

  sts_token_t  byte_tokens [$];
  sts_token_t  tokens_due [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          n_sent = 0;
  int          src_quiet = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_id_char(logic [7:0] b);
    logic [7:0] f;
    f = b | CASE_BIT;
    return (f >= "a" && f <= "z") || b == "_";
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == "\t" || b == "\r" || b == "\n" || b == " ";
  endfunction

  function automatic void push_token(logic [4:0] kind, logic [30:0] ival, logic [7:0] ch,
                                     logic [23:0] line, logic [2:0] err);
    sts_token_t t;
    t.kind        = kind;
    t.int_value   = ival;
    t.text_char   = ch;
    t.line_number = line;
    t.error_code  = err;
    t.last        = 1'b0;
    if (byte_tokens.size() < 2) byte_tokens.push_back(t);
  endfunction

  function automatic void halt_with(logic [2:0] err, logic [7:0] ch);
    push_token(KIND_ERROR, '0, ch, tok_line, err);
    scan_mode = SCAN_HALT;
  endfunction

  // Add one identifier character and drop keywords it no longer spells
  function automatic void take_id_char(logic [7:0] b);
    if (id_len >= ID_LIMIT - 2) begin
      halt_with(ERR_ID_LONG, 8'h00);
      return;
    end
    for (int k = 0; k < 3; k++) begin
      if (id_len >= kw_word[k].len() || kw_word[k][id_len] != b) kw_live[k] = 1'b0;
    end
    id_len++;
    push_token(KIND_ID_CHAR, '0, b, tok_line, ERR_NONE);
  endfunction

  // Start a new token from an idle scanner
  function automatic void scan_idle(logic [7:0] b, logic eoi);
    tok_line = line_cnt;
    if (eoi) begin
      push_token(KIND_END, '0, 8'h00, line_cnt, ERR_NONE);
      return;
    end
    if (is_space(b)) return;
    for (int k = 0; k < 10; k++) begin
      if (op_chars[k] == b) begin
        push_token(KIND_OP_PLUS + 5'(k), '0, 8'h00, tok_line, ERR_NONE);
        return;
      end
    end
    if (b == "\"") begin
      scan_mode = SCAN_STR;
    end else if (is_digit(b)) begin
      scan_mode = SCAN_INT;
      int_acc   = 31'(b - "0");
      digit_cnt = 1;
    end else if (is_id_char(b)) begin
      scan_mode = SCAN_ID;
      id_len    = 0;
      kw_live   = 3'b111;
      take_id_char(b);
    end else begin
      halt_with(ERR_BAD_CHAR, b);
    end
  endfunction

  function automatic void scan_quoted(logic [7:0] b, logic eoi);
    if (eoi) begin
      halt_with(ERR_STR_OPEN, 8'h00);
    end else if (b == "\"") begin
      push_token(KIND_STR_END, '0, 8'h00, tok_line, ERR_NONE);
      scan_mode = SCAN_IDLE;
    end else if (b == "\\") begin
      scan_mode = SCAN_ESC;
    end else begin
      push_token(KIND_STR_CHAR, '0, b, tok_line, ERR_NONE);
    end
  endfunction

  // Work out the tokens one accepted byte yields, into byte_tokens
  function automatic void scan_byte(logic [7:0] b, logic end_flag);
    logic        eoi;
    logic [63:0] v;
    logic [4:0]  kind;
    sts_token_t  t;
    byte_tokens.delete();
    eoi = end_flag || b == 8'h00;
    if (scan_mode == SCAN_HALT) return;
    if (!eoi && b == "\n" && line_cnt != LINE_MAX) line_cnt++;
    case (scan_mode)
      SCAN_INT: begin
        if (!eoi && is_digit(b)) begin
          if (digit_cnt >= DIGIT_LIMIT) begin
            halt_with(ERR_DIGITS, 8'h00);
          end else begin
            v = 64'(int_acc) * 64'd10 + 64'(b - "0");
            int_acc = (v > 64'(INT_MAX)) ? INT_MAX : v[30:0];
            digit_cnt++;
          end
        end else begin
          push_token(KIND_INT, int_acc, 8'h00, tok_line, ERR_NONE);
          scan_mode = SCAN_IDLE;
          scan_idle(b, eoi);
        end
      end
      SCAN_ID: begin
        if (!eoi && is_id_char(b)) begin
          take_id_char(b);
        end else begin
          kind = KIND_ID;
          for (int k = 0; k < 3; k++) begin
            if (kw_live[k] && id_len == kw_word[k].len()) kind = KIND_KW_GLOBAL + 5'(k);
          end
          push_token(kind, '0, 8'h00, tok_line, ERR_NONE);
          scan_mode = SCAN_IDLE;
          scan_idle(b, eoi);
        end
      end
      SCAN_STR: scan_quoted(b, eoi);
      SCAN_ESC: begin
        if (!eoi && b == "n") begin
          push_token(KIND_STR_CHAR, '0, "\n", tok_line, ERR_NONE);
          scan_mode = SCAN_STR;
        end else if (!eoi && b == "t") begin
          push_token(KIND_STR_CHAR, '0, "\t", tok_line, ERR_NONE);
          scan_mode = SCAN_STR;
        end else begin
          scan_mode = SCAN_STR;
          scan_quoted(b, eoi);
        end
      end
      default: begin
        scan_mode = SCAN_IDLE;
        scan_idle(b, eoi);
      end
    endcase
    // Mark the final token of this byte
    if (byte_tokens.size() > 0) begin
      t = byte_tokens.pop_back();
      t.last = 1'b1;
      byte_tokens.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly short pauses, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_id_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_str_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  function automatic bit in_string();
    return scan_mode == SCAN_STR || scan_mode == SCAN_ESC;
  endfunction

  // Present one byte request, wait for acceptance, then queue its tokens
  task automatic send_byte(input logic [7:0] b, input logic end_flag = 1'b0,
                           input logic typed = 1'b0, input logic [4:0] kind = KIND_END,
                           input logic [23:0] line = 24'd1);
    int         gap;
    sts_byte_t  req;
    sts_token_t t;
    if (src_quiet > 0) begin
      src_quiet--;
      gap = 0;
    end else begin
      gap = pause_len();
      if ($urandom_range(0, 149) == 0) src_quiet = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.in_byte      = b;
    req.end_of_input = end_flag;
    byte_if.data  <= req;
    byte_if.valid <= 1'b1;
    do @(posedge clk_i); while (!byte_if.ready);
    scan_byte(b, end_flag);
    if (typed) begin
      t.kind        = kind;
      t.int_value   = '0;
      t.text_char   = 8'h00;
      t.line_number = line;
      t.error_code  = ERR_NONE;
      t.last        = 1'b1;
      tokens_due.push_back(t);
    end else begin
      foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
    end
    n_sent++;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Token sink: random stalls, with stretches of none
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    int quiet;
    hold  = 0;
    quiet = 0;
    token_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        token_if.ready <= 1'b0;
        hold--;
      end else begin
        token_if.ready <= 1'b1;
        if (quiet > 0) begin
          quiet--;
        end else begin
          hold = pause_len();
          if ($urandom_range(0, 149) == 0) quiet = $urandom_range(30, 120);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token check and watchdog
  // --------------------------------------------------------------------------
  task automatic flag_token(input string why, input sts_token_t exp, input sts_token_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp kind %0d int %0d char %02h line %0d err %0d last %0b",
               $time, why, exp.kind, exp.int_value, exp.text_char, exp.line_number,
               exp.error_code, exp.last);
      $display("%0t %s: got kind %0d int %0d char %02h line %0d err %0d last %0b",
               $time, why, got.kind, got.int_value, got.text_char, got.line_number,
               got.error_code, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    sts_token_t got;
    sts_token_t exp;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycles, tokens_due.size());
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni && token_if.valid && token_if.ready) begin
      got = token_if.data;
      if (tokens_due.size() == 0) begin
        flag_token("unexpected token", got, got);
      end else begin
        exp = tokens_due.pop_front();
        if (got.kind !== exp.kind || got.int_value !== exp.int_value ||
            got.text_char !== exp.text_char || got.line_number !== exp.line_number ||
            got.error_code !== exp.error_code || got.last !== exp.last)
          flag_token("token mismatch", exp, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t dir_rows [DIR_ROWS];
    int       r;
    int       n;
    string    word;
    string    word_pool [14] = '{"global", "none", "__asm", "Global", "globals", "glob",
                                 "non", "nonE", "nones", "__as", "__asm_", "_", "x",
                                 "_asm"};
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, KIND_END,       24'd1},
      '{"+",   1'b0, 1'b1, KIND_OP_PLUS,   24'd1},
      '{"-",   1'b0, 1'b1, KIND_OP_MINUS,  24'd1},
      '{"*",   1'b0, 1'b1, KIND_OP_STAR,   24'd1},
      '{"/",   1'b0, 1'b1, KIND_OP_SLASH,  24'd1},
      '{"(",   1'b0, 1'b1, KIND_OP_LPAREN, 24'd1},
      '{")",   1'b0, 1'b1, KIND_OP_RPAREN, 24'd1},
      '{";",   1'b0, 1'b1, KIND_OP_SEMI,   24'd1},
      '{"{",   1'b0, 1'b1, KIND_OP_LBRACE, 24'd1},
      '{"}",   1'b0, 1'b1, KIND_OP_RBRACE, 24'd1},
      '{">",   1'b0, 1'b1, KIND_OP_GT,     24'd1},
      '{"\n",  1'b0, 1'b0, KIND_END,       24'd1},
      '{"9",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"(",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"n",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"o",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"n",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"e",   1'b0, 1'b0, KIND_END,       24'd1},
      '{";",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"\"",  1'b0, 1'b0, KIND_END,       24'd1},
      '{"\\",  1'b0, 1'b0, KIND_END,       24'd1},
      '{"t",   1'b0, 1'b0, KIND_END,       24'd1},
      '{"\\",  1'b0, 1'b0, KIND_END,       24'd1},
      '{"\"",  1'b0, 1'b0, KIND_END,       24'd1},
      '{8'hFF, 1'b1, 1'b0, KIND_END,       24'd1}
    };

    // Reset the predictor alongside the block
    scan_mode = SCAN_IDLE;
    int_acc   = '0;
    digit_cnt = 0;
    id_len    = 0;
    kw_live   = 3'b111;
    line_cnt  = 24'd1;
    tok_line  = 24'd1;

    rst_ni        = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the fixed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].in_byte, dir_rows[i].end_flag, dir_rows[i].typed,
                dir_rows[i].kind, dir_rows[i].line);

    // Random source text, built token by token
    while (n_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_byte(op_chars[$urandom_range(0, 9)]);
      end else if (r < 40) begin
        // Separate from a running integer so digits never merge
        if (scan_mode == SCAN_INT) send_byte(" ");
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(1, 4) : (r < 90) ? $urandom_range(5, 10)
                                                       : $urandom_range(11, DIGIT_LIMIT);
        repeat (n) send_byte(rand_digit());
      end else if (r < 65) begin
        if (scan_mode == SCAN_ID) send_byte(" ");
        r = $urandom_range(0, 99);
        if (r < 40) begin
          word = word_pool[$urandom_range(0, 13)];
          for (int i = 0; i < word.len(); i++) send_byte(word[i]);
        end else begin
          n = (r < 95) ? $urandom_range(1, 8) : $urandom_range(25, ID_LIMIT - 2);
          repeat (n) send_byte(rand_id_char());
        end
      end else if (r < 77) begin
        send_byte("\"");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          if (!in_string()) break;
          r = $urandom_range(0, 99);
          if (r < 12) begin
            send_byte("\\");
            r = $urandom_range(0, 2);
            send_byte(r == 0 ? "n" : r == 1 ? "t" : 8'($urandom_range(1, 255)));
          end else if (r < 18) begin
            send_byte("\n");
          end else begin
            send_byte(rand_str_char());
          end
        end
        // Close the string unless an escaped quote already did
        if (in_string()) send_byte("\"");
      end else if (r < 95) begin
        r = $urandom_range(0, 3);
        send_byte(r == 0 ? " " : r == 1 ? "\t" : r == 2 ? "\r" : "\n");
      end else begin
        if ($urandom_range(0, 1) == 0) send_byte(8'h00);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    // End on one error; the block then drops every byte
    case ($urandom_range(0, 3))
      0: begin
        if (scan_mode == SCAN_INT) send_byte(" ");
        repeat (DIGIT_LIMIT + 1) send_byte(rand_digit());
      end
      1: begin
        if (scan_mode == SCAN_ID) send_byte(" ");
        repeat (ID_LIMIT - 1) send_byte(rand_id_char());
      end
      2: begin
        send_byte("\"");
        if ($urandom_range(0, 1) == 0) send_byte("\n");
        repeat ($urandom_range(0, 5)) send_byte(rand_str_char());
        if ($urandom_range(0, 1) == 0) send_byte(8'h00);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        do r = $urandom_range(1, 255);
        while (is_space(8'(r)) || is_digit(8'(r)) || is_id_char(8'(r)) || r == "\"" ||
               r == "+" || r == "-" || r == "*" || r == "/" || r == "(" || r == ")" ||
               r == ";" || r == "{" || r == "}" || r == ">");
        send_byte(8'(r));
      end
    endcase
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    byte_if.valid <= 1'b0;

    // Drain, then watch for stray tokens
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sts_pkg.sv
hdl/sts_stream_if.sv
hdl/source_token_scanner.sv
verif/tb_source_token_scanner.sv
